[design/bankers_safety_allocator_assert.svh]
// Assertion macros shared by the allocator RTL
`ifndef BANKERS_SAFETY_ALLOCATOR_ASSERT_SVH
`define BANKERS_SAFETY_ALLOCATOR_ASSERT_SVH

// cond holds at every edge out of reset
`define BSA_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("bankers_safety_allocator: invariant violated");

// same-cycle implication
`define BSA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bankers_safety_allocator: implication violated");

// next-cycle implication
`define BSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bankers_safety_allocator: sequence violated");

`endif

[design/bsa_pkg.sv]
package bsa_pkg;

    localparam int VAL_W = 8;
    localparam int SEQ_W = 3;

    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_SET_AVAIL = 2'd1,
        CMD_REQUEST   = 2'd2,
        CMD_SAFETY    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_GRANTED  = 3'd1,
        ST_EXCEEDS  = 3'd2,
        ST_WAIT     = 3'd3,
        ST_UNSAFE   = 3'd4,
        ST_SEQ      = 3'd5,
        ST_NOT_SAFE = 3'd6,
        ST_BAD_LOAD = 3'd7
    } status_t;

endpackage

[design/bsa_ram.sv]
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/bsa_table.sv]
module bsa_table #(
    parameter int ROWS  = 8,
    parameter int ROW_W = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    we,
    input  logic [$clog2(ROWS)-1:0] waddr,
    input  logic [ROW_W-1:0]        wdata,
    input  logic [$clog2(ROWS)-1:0] raddr,
    output logic [ROW_W-1:0]        rdata
);

    logic [ROWS-1:0]  valid_reg;
    logic [ROWS-1:0]  valid_next;
    logic             rvalid_reg;
    logic [ROW_W-1:0] ram_rdata;

    // rows never written read as zero
    bsa_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? ram_rdata : '0;

endmodule

[design/bankers_safety_allocator.sv]
// Banker's-algorithm resource allocator. Claim and held counts live in one
// row per process of a single-port-write RAM (one read per cycle, registered);
// the available vector sits in flip-flops. Set available, a load entry, a
// rejected load and a rejected request each give one item. A safety check,
// alone or behind a tentatively granted request, scans the table one process
// per clock, as set by the single table read port, repeating passes in index
// order while any process finishes. A safe check alone then gives PROCESSES
// sequence items, one per cycle while the output is free; a safe request
// gives one granted item. The output register lets a new command be taken
// while the last result still waits.
module bankers_safety_allocator #(
    parameter int PROCESSES = 8,
    parameter int RESOURCES = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  logic [2:0] process,
    input  logic [1:0] resource,
    input  logic [7:0] max_claim,
    input  logic [7:0] held,
    input  logic [7:0] amount,
    input  logic [7:0] request_0,
    input  logic [7:0] request_1,
    input  logic [7:0] request_2,
    input  logic [7:0] request_3,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic [2:0] sequence_process,
    output logic       last
);

    import bsa_pkg::*;

    `include "bankers_safety_allocator_assert.svh"

    localparam int PIDX_W = $clog2(PROCESSES);
    localparam int CNT_W  = $clog2(PROCESSES + 1);
    localparam int WORK_W = VAL_W + CNT_W;
    localparam int LANE_W = 2 * VAL_W;
    localparam int ROW_W  = LANE_W * RESOURCES;
    localparam logic [PIDX_W-1:0] LAST_IDX = PIDX_W'(PROCESSES - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(PROCESSES);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_LOAD_RD = 6'b000010,
        S_REQ_RD  = 6'b000100,
        S_CHECK   = 6'b001000,
        S_RESP    = 6'b010000,
        S_EMIT    = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic                mode_req_reg, mode_req_next;
    logic [PIDX_W-1:0]   proc_reg, proc_next;
    logic [1:0]          res_reg, res_next;
    logic [VAL_W-1:0]    claim_in_reg, claim_in_next;
    logic [VAL_W-1:0]    held_in_reg, held_in_next;
    logic [VAL_W-1:0]    req_reg [RESOURCES];
    logic [VAL_W-1:0]    req_next [RESOURCES];
    logic [ROW_W-1:0]    old_row_reg, old_row_next;
    logic [VAL_W-1:0]    avail_reg [RESOURCES];
    logic [VAL_W-1:0]    avail_next [RESOURCES];
    logic [WORK_W-1:0]   work_reg [RESOURCES];
    logic [WORK_W-1:0]   work_next [RESOURCES];
    logic [PROCESSES-1:0] done_reg, done_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                progress_reg, progress_next;
    logic [PIDX_W-1:0]   issue_idx_reg, issue_idx_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [PIDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [PIDX_W-1:0]   order_reg [PROCESSES];
    logic [PIDX_W-1:0]   order_next [PROCESSES];
    logic [PIDX_W-1:0]   emit_idx_reg, emit_idx_next;
    status_t             resp_reg, resp_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [SEQ_W-1:0]    out_seq_reg, out_seq_next;
    logic                out_last_reg, out_last_next;

    logic                mem_we;
    logic [PIDX_W-1:0]   mem_waddr;
    logic [ROW_W-1:0]    mem_wdata;
    logic [PIDX_W-1:0]   mem_raddr;
    logic [ROW_W-1:0]    mem_rdata;
    logic [VAL_W-1:0]    req_in [4];

    assign req_in[0] = request_0;
    assign req_in[1] = request_1;
    assign req_in[2] = request_2;
    assign req_in[3] = request_3;

    bsa_table #(
        .ROWS  (PROCESSES),
        .ROW_W (ROW_W)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        logic [VAL_W-1:0]  c8;
        logic [VAL_W-1:0]  h8;
        logic [VAL_W-1:0]  need8;
        logic [WORK_W-1:0] needw;
        logic              fail;
        status_t           fail_st;
        logic              fits;
        logic [CNT_W-1:0]  cnt_v;
        logic              prog_v;
        logic              finish_safe;
        logic              finish_unsafe;
        logic              out_free;

        state_next      = state_reg;
        mode_req_next   = mode_req_reg;
        proc_next       = proc_reg;
        res_next        = res_reg;
        claim_in_next   = claim_in_reg;
        held_in_next    = held_in_reg;
        req_next        = req_reg;
        old_row_next    = old_row_reg;
        avail_next      = avail_reg;
        work_next       = work_reg;
        done_next       = done_reg;
        count_next      = count_reg;
        progress_next   = progress_reg;
        issue_idx_next  = issue_idx_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        order_next      = order_reg;
        emit_idx_next   = emit_idx_reg;
        resp_next       = resp_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_seq_next    = out_seq_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = proc_reg;
        mem_wdata       = mem_rdata;
        mem_raddr       = proc_reg;
        fail            = 1'b0;
        fail_st         = ST_ACCEPTED;
        fits            = 1'b0;
        cnt_v           = count_reg;
        prog_v          = progress_reg;
        finish_safe     = 1'b0;
        finish_unsafe   = 1'b0;
        c8              = '0;
        h8              = '0;
        need8           = '0;
        needw           = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        out_free = !out_valid_reg || out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = PIDX_W'(process);
                if (in_valid)
                begin
                    proc_next     = PIDX_W'(process);
                    res_next      = resource;
                    claim_in_next = max_claim;
                    held_in_next  = held;
                    for (int r = 0; r < RESOURCES; r++)
                    begin
                        req_next[r] = req_in[r];
                    end
                    unique case (cmd_t'(command))
                        CMD_LOAD:
                        begin
                            if (int'(process) >= PROCESSES || int'(resource) >= RESOURCES
                                || held > max_claim)
                            begin
                                resp_next  = ST_BAD_LOAD;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_LOAD_RD;
                            end
                        end
                        CMD_SET_AVAIL:
                        begin
                            if (int'(resource) >= RESOURCES)
                            begin
                                resp_next = ST_BAD_LOAD;
                            end
                            else
                            begin
                                for (int r = 0; r < RESOURCES; r++)
                                begin
                                    if (int'(resource) == r)
                                    begin
                                        avail_next[r] = amount;
                                    end
                                end
                                resp_next = ST_ACCEPTED;
                            end
                            state_next = S_RESP;
                        end
                        CMD_REQUEST:
                        begin
                            if (int'(process) >= PROCESSES)
                            begin
                                resp_next  = ST_EXCEEDS;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_REQ_RD;
                            end
                        end
                        CMD_SAFETY:
                        begin
                            for (int r = 0; r < RESOURCES; r++)
                            begin
                                work_next[r] = WORK_W'(avail_reg[r]);
                            end
                            mode_req_next  = 1'b0;
                            done_next      = '0;
                            count_next     = '0;
                            progress_next  = 1'b0;
                            issue_idx_next = '0;
                            state_next     = S_CHECK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_LOAD_RD:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                for (int r = 0; r < RESOURCES; r++)
                begin
                    if (int'(res_reg) == r)
                    begin
                        mem_wdata[r*LANE_W +: VAL_W]         = claim_in_reg;
                        mem_wdata[r*LANE_W + VAL_W +: VAL_W] = held_in_reg;
                    end
                end
                resp_next  = ST_ACCEPTED;
                state_next = S_RESP;
            end

            S_REQ_RD:
            begin
                for (int r = 0; r < RESOURCES; r++)
                begin
                    c8    = mem_rdata[r*LANE_W +: VAL_W];
                    h8    = mem_rdata[r*LANE_W + VAL_W +: VAL_W];
                    need8 = c8 - h8;
                    if (!fail)
                    begin
                        if (req_reg[r] > need8)
                        begin
                            fail    = 1'b1;
                            fail_st = ST_EXCEEDS;
                        end
                        else if (req_reg[r] > avail_reg[r])
                        begin
                            fail    = 1'b1;
                            fail_st = ST_WAIT;
                        end
                    end
                end
                if (fail)
                begin
                    resp_next  = fail_st;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_we       = 1'b1;
                    mem_wdata    = mem_rdata;
                    old_row_next = mem_rdata;
                    for (int r = 0; r < RESOURCES; r++)
                    begin
                        h8 = mem_rdata[r*LANE_W + VAL_W +: VAL_W];
                        mem_wdata[r*LANE_W + VAL_W +: VAL_W] = h8 + req_reg[r];
                        avail_next[r] = avail_reg[r] - req_reg[r];
                        work_next[r]  = WORK_W'(avail_reg[r] - req_reg[r]);
                    end
                    mode_req_next  = 1'b1;
                    done_next      = '0;
                    count_next     = '0;
                    progress_next  = 1'b0;
                    issue_idx_next = '0;
                    state_next     = S_CHECK;
                end
            end

            S_CHECK:
            begin
                // one row read per cycle; the compare works on the registered read data, flagged by rd_pend_reg
                mem_raddr      = issue_idx_reg;
                issue_idx_next = (issue_idx_reg == LAST_IDX) ? '0 : issue_idx_reg + 1'b1;
                rd_pend_next   = 1'b1;
                rd_idx_next    = issue_idx_reg;
                if (rd_pend_reg)
                begin
                    fits = !done_reg[rd_idx_reg];
                    for (int r = 0; r < RESOURCES; r++)
                    begin
                        c8    = mem_rdata[r*LANE_W +: VAL_W];
                        h8    = mem_rdata[r*LANE_W + VAL_W +: VAL_W];
                        needw = WORK_W'(c8) - WORK_W'(h8);
                        if (needw > work_reg[r])
                        begin
                            fits = 1'b0;
                        end
                    end
                    if (fits)
                    begin
                        for (int r = 0; r < RESOURCES; r++)
                        begin
                            h8 = mem_rdata[r*LANE_W + VAL_W +: VAL_W];
                            work_next[r] = work_reg[r] + WORK_W'(h8);
                        end
                        done_next[rd_idx_reg]                = 1'b1;
                        order_next[count_reg[PIDX_W-1:0]]    = rd_idx_reg;
                        cnt_v                                = count_reg + 1'b1;
                        prog_v                               = 1'b1;
                    end
                    count_next    = cnt_v;
                    progress_next = prog_v;
                    if (cnt_v == FULL_CNT)
                    begin
                        finish_safe = 1'b1;
                    end
                    else if (rd_idx_reg == LAST_IDX)
                    begin
                        if (!prog_v)
                        begin
                            finish_unsafe = 1'b1;
                        end
                        progress_next = 1'b0;
                    end
                end
                if (finish_safe)
                begin
                    rd_pend_next = 1'b0;
                    if (mode_req_reg)
                    begin
                        resp_next  = ST_GRANTED;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        emit_idx_next = '0;
                        state_next    = S_EMIT;
                    end
                end
                else if (finish_unsafe)
                begin
                    rd_pend_next = 1'b0;
                    if (mode_req_reg)
                    begin
                        // roll back the tentative grant
                        mem_we    = 1'b1;
                        mem_waddr = proc_reg;
                        mem_wdata = old_row_reg;
                        for (int r = 0; r < RESOURCES; r++)
                        begin
                            avail_next[r] = avail_reg[r] + req_reg[r];
                        end
                        resp_next = ST_UNSAFE;
                    end
                    else
                    begin
                        resp_next = ST_NOT_SAFE;
                    end
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = resp_reg;
                    out_seq_next    = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_SEQ;
                    out_seq_next    = SEQ_W'(order_reg[emit_idx_reg]);
                    out_last_next   = (emit_idx_reg == LAST_IDX);
                    emit_idx_next   = emit_idx_reg + 1'b1;
                    if (emit_idx_reg == LAST_IDX)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_req_reg  <= 1'b0;
            done_reg      <= '0;
            count_reg     <= '0;
            progress_reg  <= 1'b0;
            issue_idx_reg <= '0;
            rd_pend_reg   <= 1'b0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int r = 0; r < RESOURCES; r++)
            begin
                avail_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            mode_req_reg  <= mode_req_next;
            done_reg      <= done_next;
            count_reg     <= count_next;
            progress_reg  <= progress_next;
            issue_idx_reg <= issue_idx_next;
            rd_pend_reg   <= rd_pend_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            avail_reg     <= avail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        proc_reg       <= proc_next;
        res_reg        <= res_next;
        claim_in_reg   <= claim_in_next;
        held_in_reg    <= held_in_next;
        req_reg        <= req_next;
        old_row_reg    <= old_row_next;
        work_reg       <= work_next;
        rd_idx_reg     <= rd_idx_next;
        order_reg      <= order_next;
        resp_reg       <= resp_next;
        out_status_reg <= out_status_next;
        out_seq_reg    <= out_seq_next;
        out_last_reg   <= out_last_next;
    end

    assign in_ready         = (state_reg == S_IDLE);
    assign out_valid        = out_valid_reg;
    assign status           = out_status_reg;
    assign sequence_process = out_seq_reg;
    assign last             = out_last_reg;

    `BSA_ASSERT_ALWAYS(a_done_matches_count, clk, rst_n, $countones(done_reg) == count_reg)
    `BSA_ASSERT_IMPLIES(a_emit_after_full_scan, clk, rst_n,
                        state_reg == S_EMIT, count_reg == FULL_CNT)
    `BSA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, !in_ready)
    `BSA_ASSERT_IMPLIES(a_no_write_when_quiet, clk, rst_n,
                        state_reg == S_IDLE || state_reg == S_RESP || state_reg == S_EMIT,
                        !mem_we)
    `BSA_ASSERT_IMPLIES(a_compare_follows_read, clk, rst_n,
                        rd_pend_reg, $past(state_reg == S_CHECK))

endmodule
